### rtl/sbs_pkg.sv
// ----------------------------------------------------------------------------
// Stream bitrate statistics package
// Field widths, configuration register indexes and sequencer constants.
// ----------------------------------------------------------------------------
package sbs_pkg;

	localparam int SID_W      = 4;
	localparam int PKT_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int BYTES_W    = 32;
	localparam int SUM_W      = 48;
	localparam int FRAME_W    = 32;
	localparam int IVL_W      = 16;
	localparam int LEN_W      = 11;
	localparam int SCNT_W     = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_STREAM     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAM_COUNT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INTERVAL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_LENGTH = 3'd3;

	localparam logic REC_TOTAL  = 1'b0;
	localparam logic REC_STREAM = 1'b1;

	localparam int DIV_DVD_W = 44;
	localparam int DIV_DSR_W = 16;
	localparam int DIV_STEPS = 44;
	localparam int STEP_W    = 6;

endpackage

### rtl/sbs_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sbs_cfg_if import sbs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/sbs_pkt_if.sv
// ----------------------------------------------------------------------------
// Packet channel
// One packet per transaction: stream number and byte size.
// ----------------------------------------------------------------------------
interface sbs_pkt_if import sbs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SID_W-1:0] stream_number;
	logic [PKT_W-1:0] packet_bytes;

	modport source (output valid, output stream_number, output packet_bytes, input ready);
	modport sink   (input valid, input stream_number, input packet_bytes, output ready);
endinterface

### rtl/sbs_rec_if.sv
// ----------------------------------------------------------------------------
// Record channel
// One statistics record per transaction, total or per stream.
// ----------------------------------------------------------------------------
interface sbs_rec_if import sbs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               record_type;
	logic [SID_W-1:0]   stream_id;
	logic [BYTES_W-1:0] interval_bytes;
	logic [BYTES_W-1:0] smoothed_bytes;
	logic [BYTES_W-1:0] minimum_bytes;
	logic [BYTES_W-1:0] maximum_bytes;
	logic [SUM_W-1:0]   accumulated_bytes;
	logic [FRAME_W-1:0] frame_index;
	logic               last_record;

	modport source (output valid, output record_type, output stream_id,
		output interval_bytes, output smoothed_bytes, output minimum_bytes,
		output maximum_bytes, output accumulated_bytes, output frame_index,
		output last_record, input ready);
	modport sink (input valid, input record_type, input stream_id,
		input interval_bytes, input smoothed_bytes, input minimum_bytes,
		input maximum_bytes, input accumulated_bytes, input frame_index,
		input last_record, output ready);
endinterface

### rtl/stream_bitrate_statistics.sv
// ----------------------------------------------------------------------------
// Stream bitrate statistics
// Per-stream byte counts with periodic total and per-stream reports.
// ----------------------------------------------------------------------------
// Usage: packets (stream number, byte size) arrive on pkt; the user must write
// registers on cfg (always ready) only while the block is idle, which the block
// itself does not enforce. Packets of streams at or above the stream count are
// dropped. Each video packet advances the report counter; a report emits one
// total record, then one record per stream in use on rec, the final one flagged
// by last_record. An ordinary packet passes accept, counter read and counter
// write before the next packet is accepted, set by the read-modify-write of the
// stream counter memory. A report packet then sums the streams, runs two
// divisions on the shared restoring divider with a multiply step between them,
// and emits the records. The total record is presented after the second
// division, and the stream records follow it in stream order, each after the
// read of its stream counter.
// Records sit in an output register; the next packet is accepted while the
// last record still waits. A stalled receiver holds the sequencer at the
// record it is about to emit. Reset restores register defaults, clears all
// statistics through per-stream valid bits, and needs no clearing pass.
// ----------------------------------------------------------------------------
module stream_bitrate_statistics import sbs_pkg::*; #(
	parameter int MAX_STREAMS = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	sbs_cfg_if.sink    cfg,
	sbs_pkt_if.sink    pkt,
	sbs_rec_if.source  rec
);

	localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int CNT_W = $clog2(MAX_STREAMS + 1);
	localparam int AW    = ((COUNT_WIDTH > PKT_W) ? COUNT_WIDTH : PKT_W) + 1;
	localparam int ENT_W = COUNT_WIDTH + BYTES_W + BYTES_W + SUM_W;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_PK_RD   = 4'd1;
	localparam logic [3:0] ST_PK_UPD  = 4'd2;
	localparam logic [3:0] ST_SUM_RD  = 4'd3;
	localparam logic [3:0] ST_SUM_ACC = 4'd4;
	localparam logic [3:0] ST_DIV1    = 4'd5;
	localparam logic [3:0] ST_MUL     = 4'd6;
	localparam logic [3:0] ST_DIV2    = 4'd7;
	localparam logic [3:0] ST_TOT_OUT = 4'd8;
	localparam logic [3:0] ST_SRD     = 4'd9;
	localparam logic [3:0] ST_SUPD    = 4'd10;

	logic [3:0]             state_q;
	logic [SID_W-1:0]       video_q;
	logic [SCNT_W-1:0]      scnt_q;
	logic [IVL_W-1:0]       ivl_cfg_q;
	logic [LEN_W-1:0]       len_cfg_q;

	logic [CNT_W-1:0]       count_eff;
	logic [IVL_W-1:0]       ivl;
	logic [LEN_W-1:0]       len;

	logic [SID_W-1:0]       sid_q;
	logic [PKT_W-1:0]       pbytes_q;
	logic [IDX_W-1:0]       idx_q;
	logic [MAX_STREAMS-1:0] vld_q;

	logic [COUNT_WIDTH-1:0] total_q;
	logic [BYTES_W-1:0]     tmin_q;
	logic [BYTES_W-1:0]     tmax_q;
	logic [SUM_W-1:0]       tsum_q;
	logic [BYTES_W-1:0]     smooth_q;
	logic [IVL_W-1:0]       ivc_q;
	logic [FRAME_W-1:0]     fcnt_q;
	logic [FRAME_W-1:0]     frame_q;

	logic [DIV_DVD_W-1:0]   dvd_q;
	logic [DIV_DSR_W-1:0]   rem_q;
	logic [DIV_DSR_W-1:0]   dsr_q;
	logic [STEP_W-1:0]      step_q;

	logic                   rec_valid_q;
	logic                   rec_type_q;
	logic [SID_W-1:0]       rec_id_q;
	logic [BYTES_W-1:0]     rec_ivl_q;
	logic [BYTES_W-1:0]     rec_smooth_q;
	logic [BYTES_W-1:0]     rec_min_q;
	logic [BYTES_W-1:0]     rec_max_q;
	logic [SUM_W-1:0]       rec_acc_q;
	logic [FRAME_W-1:0]     rec_frame_q;
	logic                   rec_last_q;

	logic [IDX_W-1:0]       raddr;
	logic                   we;
	logic [ENT_W-1:0]       wdata;
	logic [ENT_W-1:0]       rdata;
	logic [ENT_W-1:0]       ent;
	logic [COUNT_WIDTH-1:0] ent_bytes;
	logic [BYTES_W-1:0]     ent_min;
	logic [BYTES_W-1:0]     ent_max;
	logic [SUM_W-1:0]       ent_sum;

	logic [AW-1:0]          pk_sum;
	logic [COUNT_WIDTH-1:0] pk_bytes_new;
	logic [COUNT_WIDTH:0]   tot_sum;
	logic [COUNT_WIDTH-1:0] tot_next;
	logic [BYTES_W-1:0]     tot32;
	logic [BYTES_W-1:0]     b32;
	logic [BYTES_W-1:0]     s_min;
	logic [BYTES_W-1:0]     s_max;
	logic [SUM_W:0]         s_sum_w;
	logic [SUM_W-1:0]       s_sum;
	logic [BYTES_W-1:0]     t_min;
	logic [BYTES_W-1:0]     t_max;
	logic [SUM_W:0]         t_sum_w;
	logic [SUM_W-1:0]       t_sum;
	logic [DIV_DSR_W:0]     div_r;
	logic                   div_ge;
	logic [DIV_DVD_W-1:0]   prod;
	logic                   slot_free;
	logic                   rec_load;
	logic                   last_idx;
	logic                   pkt_acc;
	logic                   pkt_in_use;

	always_comb begin
		if (scnt_q == '0) begin
			count_eff = CNT_W'(1);
		end else if (int'(scnt_q) > MAX_STREAMS) begin
			count_eff = CNT_W'(MAX_STREAMS);
		end else begin
			count_eff = CNT_W'(scnt_q);
		end
		ivl = (ivl_cfg_q == '0) ? IVL_W'(1) : ivl_cfg_q;
		len = (len_cfg_q == '0) ? LEN_W'(1) : len_cfg_q;
	end

	assign cfg.ready  = 1'b1;
	assign pkt.ready  = (state_q == ST_IDLE);
	assign pkt_acc    = pkt.valid && pkt.ready;
	assign pkt_in_use = 32'(pkt.stream_number) < 32'(count_eff);
	assign slot_free  = !rec_valid_q || rec.ready;
	assign rec_load   = slot_free && ((state_q == ST_TOT_OUT) || (state_q == ST_SUPD));
	assign last_idx   = (CNT_W'(idx_q) + CNT_W'(1)) == count_eff;

	assign raddr = ((state_q == ST_PK_RD) || (state_q == ST_PK_UPD)) ? IDX_W'(sid_q) : idx_q;

	sbs_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_STREAMS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (raddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		ent       = vld_q[raddr] ? rdata : {{COUNT_WIDTH{1'b0}}, {BYTES_W{1'b1}},
			{BYTES_W{1'b0}}, {SUM_W{1'b0}}};
		ent_bytes = ent[ENT_W-1 -: COUNT_WIDTH];
		ent_min   = ent[BYTES_W+BYTES_W+SUM_W-1 -: BYTES_W];
		ent_max   = ent[BYTES_W+SUM_W-1 -: BYTES_W];
		ent_sum   = ent[SUM_W-1:0];

		pk_sum       = AW'(ent_bytes) + AW'(pbytes_q);
		pk_bytes_new = (|pk_sum[AW-1:COUNT_WIDTH]) ? {COUNT_WIDTH{1'b1}} : pk_sum[COUNT_WIDTH-1:0];

		tot_sum  = {1'b0, total_q} + {1'b0, ent_bytes};
		tot_next = tot_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : tot_sum[COUNT_WIDTH-1:0];
		tot32    = BYTES_W'(total_q);

		b32     = BYTES_W'(ent_bytes);
		s_min   = (b32 < ent_min) ? b32 : ent_min;
		s_max   = (b32 > ent_max) ? b32 : ent_max;
		s_sum_w = {1'b0, ent_sum} + (SUM_W+1)'(b32);
		s_sum   = s_sum_w[SUM_W] ? {SUM_W{1'b1}} : s_sum_w[SUM_W-1:0];

		t_min   = (tot32 < tmin_q) ? tot32 : tmin_q;
		t_max   = (tot32 > tmax_q) ? tot32 : tmax_q;
		t_sum_w = {1'b0, tsum_q} + (SUM_W+1)'(tot32);
		t_sum   = t_sum_w[SUM_W] ? {SUM_W{1'b1}} : t_sum_w[SUM_W-1:0];

		div_r  = {rem_q, dvd_q[DIV_DVD_W-1]};
		div_ge = div_r >= {1'b0, dsr_q};

		prod = DIV_DVD_W'(smooth_q) * DIV_DVD_W'(len - LEN_W'(1)) +
			DIV_DVD_W'(dvd_q[BYTES_W-1:0]);

		we    = 1'b0;
		wdata = {pk_bytes_new, ent_min, ent_max, ent_sum};
		if (state_q == ST_PK_UPD) begin
			we = 1'b1;
		end else if ((state_q == ST_SUPD) && slot_free) begin
			we    = 1'b1;
			wdata = {{COUNT_WIDTH{1'b0}}, s_min, s_max, s_sum};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_q   <= '0;
			scnt_q    <= SCNT_W'(16);
			ivl_cfg_q <= IVL_W'(1);
			len_cfg_q <= LEN_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_VIDEO_STREAM:     video_q   <= cfg.data[SID_W-1:0];
				CFG_STREAM_COUNT:     scnt_q    <= cfg.data[SCNT_W-1:0];
				CFG_REPORT_INTERVAL:  ivl_cfg_q <= cfg.data[IVL_W-1:0];
				CFG_SMOOTHING_LENGTH: len_cfg_q <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			tmin_q      <= '1;
			tmax_q      <= '0;
			tsum_q      <= '0;
			smooth_q    <= '0;
			ivc_q       <= '0;
			fcnt_q      <= '0;
			rec_valid_q <= 1'b0;
		end else begin
			if (rec_load) begin
				rec_valid_q <= 1'b1;
			end else if (rec.ready) begin
				rec_valid_q <= 1'b0;
			end
			if (we) begin
				vld_q[raddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pkt_acc && pkt_in_use) begin
						state_q <= ST_PK_RD;
					end
				end
				ST_PK_RD: begin
					state_q <= ST_PK_UPD;
				end
				ST_PK_UPD: begin
					state_q <= ST_IDLE;
					if (sid_q == video_q) begin
						if (fcnt_q != '1) begin
							fcnt_q <= fcnt_q + FRAME_W'(1);
						end
						if (ivc_q < ivl) begin
							ivc_q <= ivc_q + IVL_W'(1);
						end else begin
							ivc_q   <= IVL_W'(1);
							state_q <= ST_SUM_RD;
						end
					end
				end
				ST_SUM_RD: begin
					state_q <= ST_SUM_ACC;
				end
				ST_SUM_ACC: begin
					state_q <= last_idx ? ST_DIV1 : ST_SUM_RD;
				end
				ST_DIV1: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						smooth_q <= {dvd_q[BYTES_W-2:0], div_ge};
						state_q  <= ST_TOT_OUT;
					end
				end
				ST_TOT_OUT: begin
					if (slot_free) begin
						tmin_q  <= t_min;
						tmax_q  <= t_max;
						tsum_q  <= t_sum;
						state_q <= ST_SRD;
					end
				end
				ST_SRD: begin
					state_q <= ST_SUPD;
				end
				ST_SUPD: begin
					if (slot_free) begin
						state_q <= last_idx ? ST_IDLE : ST_SRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sid_q    <= pkt.stream_number;
				pbytes_q <= pkt.packet_bytes;
			end
			ST_PK_UPD: begin
				frame_q <= fcnt_q;
				idx_q   <= '0;
				total_q <= '0;
			end
			ST_SUM_ACC: begin
				total_q <= tot_next;
				idx_q   <= last_idx ? '0 : idx_q + IDX_W'(1);
				dvd_q   <= DIV_DVD_W'(BYTES_W'(tot_next));
				rem_q   <= '0;
				dsr_q   <= DIV_DSR_W'(ivl);
				step_q  <= '0;
			end
			ST_DIV1, ST_DIV2: begin
				dvd_q  <= {dvd_q[DIV_DVD_W-2:0], div_ge};
				rem_q  <= div_ge ? DIV_DSR_W'(div_r - {1'b0, dsr_q}) : div_r[DIV_DSR_W-1:0];
				step_q <= step_q + STEP_W'(1);
			end
			ST_MUL: begin
				dvd_q  <= prod;
				rem_q  <= '0;
				dsr_q  <= DIV_DSR_W'(len);
				step_q <= '0;
			end
			ST_TOT_OUT: begin
				if (slot_free) begin
					rec_type_q   <= REC_TOTAL;
					rec_id_q     <= '0;
					rec_ivl_q    <= tot32;
					rec_smooth_q <= smooth_q;
					rec_min_q    <= t_min;
					rec_max_q    <= t_max;
					rec_acc_q    <= t_sum;
					rec_frame_q  <= frame_q;
					rec_last_q   <= 1'b0;
				end
			end
			ST_SUPD: begin
				if (slot_free) begin
					rec_type_q   <= REC_STREAM;
					rec_id_q     <= SID_W'(idx_q);
					rec_ivl_q    <= b32;
					rec_smooth_q <= '0;
					rec_min_q    <= s_min;
					rec_max_q    <= s_max;
					rec_acc_q    <= s_sum;
					rec_frame_q  <= frame_q;
					rec_last_q   <= last_idx;
					idx_q        <= idx_q + IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign rec.valid             = rec_valid_q;
	assign rec.record_type       = rec_type_q;
	assign rec.stream_id         = rec_id_q;
	assign rec.interval_bytes    = rec_ivl_q;
	assign rec.smoothed_bytes    = rec_smooth_q;
	assign rec.minimum_bytes     = rec_min_q;
	assign rec.maximum_bytes     = rec_max_q;
	assign rec.accumulated_bytes = rec_acc_q;
	assign rec.frame_index       = rec_frame_q;
	assign rec.last_record       = rec_last_q;

	a_last_is_stream: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid_q && rec_last_q |-> rec_type_q == REC_STREAM)
		else $error("last record flag on a total record");

	a_min_max_order: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid_q |-> (rec_min_q <= rec_ivl_q) && (rec_ivl_q <= rec_max_q))
		else $error("interval count outside running minimum and maximum");

	a_acc_covers: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid_q |-> rec_acc_q >= SUM_W'(rec_ivl_q))
		else $error("accumulated count below interval count");

	a_busy_after_use: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_acc && pkt_in_use |=> !pkt.ready)
		else $error("packet taken while previous one in flight");

	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV1) || (state_q == ST_DIV2) |-> step_q < STEP_W'(DIV_STEPS))
		else $error("divider step count overrun");

endmodule

### rtl/sbs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### test/sbs_checker.sv
// ----------------------------------------------------------------------------
// Stream bitrate statistics checker
// Watches the configuration, packet and record channels. It keeps its own
// copy of the registers and of the per-stream statistics and predicts every
// report at packet acceptance. Each record is compared field by field with
// the oldest predicted record. The failure count and the number of records
// still owed go to the testbench top.
// ----------------------------------------------------------------------------
module sbs_checker import sbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	sbs_cfg_if   cfg,
	sbs_pkt_if   pkt,
	sbs_rec_if   rec,
	output int   fail_count,
	output int   pending
);

	localparam int STREAMS    = 16;
	localparam int SHOW_LIMIT = 10;

	typedef struct packed {
		logic               record_type;
		logic [SID_W-1:0]   stream_id;
		logic [BYTES_W-1:0] interval_bytes;
		logic [BYTES_W-1:0] smoothed_bytes;
		logic [BYTES_W-1:0] minimum_bytes;
		logic [BYTES_W-1:0] maximum_bytes;
		logic [SUM_W-1:0]   accumulated_bytes;
		logic [FRAME_W-1:0] frame_index;
		logic               last_record;
	} stat_record_t;

	logic [SID_W-1:0]   video_sel;
	logic [SCNT_W-1:0]  stream_cnt;
	logic [IVL_W-1:0]   interval_len;
	logic [LEN_W-1:0]   smooth_len;

	logic [BYTES_W-1:0] bytes_now  [STREAMS];
	logic [BYTES_W-1:0] bytes_low  [STREAMS];
	logic [BYTES_W-1:0] bytes_high [STREAMS];
	logic [SUM_W-1:0]   bytes_sum  [STREAMS];
	logic [BYTES_W-1:0] total_low;
	logic [BYTES_W-1:0] total_high;
	logic [SUM_W-1:0]   total_sum;
	logic [BYTES_W-1:0] smoothed;
	logic [IVL_W-1:0]   frames_in_interval;
	logic [FRAME_W-1:0] frames_seen;

	stat_record_t report_queue [$];
	stat_record_t got_rec;
	stat_record_t want_rec;

	function automatic logic [BYTES_W-1:0] add_count(input logic [BYTES_W-1:0] a,
		input logic [BYTES_W-1:0] b);
		logic [BYTES_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[BYTES_W] ? '1 : s[BYTES_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] add_sum(input logic [SUM_W-1:0] a,
		input logic [BYTES_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {{(SUM_W-BYTES_W+1){1'b0}}, b};
		return s[SUM_W] ? '1 : s[SUM_W-1:0];
	endfunction

	function automatic string show(input stat_record_t r);
		return $sformatf("type %0d id %0d bytes %0d smoothed %0d min %0d max %0d sum %0d frame %0d last %0d",
			r.record_type, r.stream_id, r.interval_bytes, r.smoothed_bytes,
			r.minimum_bytes, r.maximum_bytes, r.accumulated_bytes, r.frame_index,
			r.last_record);
	endfunction

	task automatic tally_packet(input logic [SID_W-1:0] sid, input logic [PKT_W-1:0] nbytes);
		int unsigned        used;
		logic [IVL_W-1:0]   ivl;
		logic [LEN_W-1:0]   len;
		logic [BYTES_W-1:0] total;
		logic [FRAME_W-1:0] frame;
		longint unsigned    avg;
		stat_record_t       r;
		used = (stream_cnt == 0) ? 1 : (stream_cnt > STREAMS) ? STREAMS : stream_cnt;
		ivl = (interval_len == 0) ? IVL_W'(1) : interval_len;
		len = (smooth_len == 0) ? LEN_W'(1) : smooth_len;
		if (sid >= used)
			return;
		bytes_now[sid] = add_count(bytes_now[sid], BYTES_W'(nbytes));
		if (sid != video_sel)
			return;
		frame = frames_seen;
		if (frames_seen != '1)
			frames_seen++;
		if (frames_in_interval < ivl) begin
			frames_in_interval++;
			return;
		end
		frames_in_interval = 1;

		total = '0;
		for (int i = 0; i < used; i++)
			total = add_count(total, bytes_now[i]);
		avg = (64'(smoothed) * 64'(len - 1) + 64'(total / ivl)) / 64'(len);
		smoothed = avg[BYTES_W-1:0];
		if (total < total_low)
			total_low = total;
		if (total > total_high)
			total_high = total;
		total_sum = add_sum(total_sum, total);
		r = '{record_type: REC_TOTAL, stream_id: SID_W'(0), interval_bytes: total,
			smoothed_bytes: smoothed, minimum_bytes: total_low, maximum_bytes: total_high,
			accumulated_bytes: total_sum, frame_index: frame, last_record: 1'b0};
		report_queue.push_back(r);

		for (int i = 0; i < used; i++) begin
			if (bytes_now[i] < bytes_low[i])
				bytes_low[i] = bytes_now[i];
			if (bytes_now[i] > bytes_high[i])
				bytes_high[i] = bytes_now[i];
			bytes_sum[i] = add_sum(bytes_sum[i], bytes_now[i]);
			r = '{record_type: REC_STREAM, stream_id: SID_W'(i), interval_bytes: bytes_now[i],
				smoothed_bytes: BYTES_W'(0), minimum_bytes: bytes_low[i],
				maximum_bytes: bytes_high[i], accumulated_bytes: bytes_sum[i],
				frame_index: frame, last_record: (i == used - 1)};
			report_queue.push_back(r);
			bytes_now[i] = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_sel    = '0;
			stream_cnt   = SCNT_W'(STREAMS);
			interval_len = IVL_W'(1);
			smooth_len   = LEN_W'(1);
			for (int i = 0; i < STREAMS; i++) begin
				bytes_now[i]  = '0;
				bytes_low[i]  = '1;
				bytes_high[i] = '0;
				bytes_sum[i]  = '0;
			end
			total_low          = '1;
			total_high         = '0;
			total_sum          = '0;
			smoothed           = '0;
			frames_in_interval = '0;
			frames_seen        = '0;
			report_queue.delete();
			pending    = 0;
			fail_count = 0;
		end else begin
			if (rec.valid && rec.ready) begin
				got_rec = '{record_type: rec.record_type, stream_id: rec.stream_id,
					interval_bytes: rec.interval_bytes, smoothed_bytes: rec.smoothed_bytes,
					minimum_bytes: rec.minimum_bytes, maximum_bytes: rec.maximum_bytes,
					accumulated_bytes: rec.accumulated_bytes, frame_index: rec.frame_index,
					last_record: rec.last_record};
				if (report_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOW_LIMIT)
						$display("unexpected record: %s", show(got_rec));
				end else begin
					want_rec = report_queue.pop_front();
					if (got_rec.record_type !== want_rec.record_type ||
						got_rec.stream_id !== want_rec.stream_id ||
						got_rec.interval_bytes !== want_rec.interval_bytes ||
						got_rec.smoothed_bytes !== want_rec.smoothed_bytes ||
						got_rec.minimum_bytes !== want_rec.minimum_bytes ||
						got_rec.maximum_bytes !== want_rec.maximum_bytes ||
						got_rec.accumulated_bytes !== want_rec.accumulated_bytes ||
						got_rec.frame_index !== want_rec.frame_index ||
						got_rec.last_record !== want_rec.last_record) begin
						fail_count++;
						if (fail_count <= SHOW_LIMIT)
							$display("record mismatch\n  expected %s\n  actual   %s",
								show(want_rec), show(got_rec));
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_VIDEO_STREAM:     video_sel    = cfg.data[SID_W-1:0];
					CFG_STREAM_COUNT:     stream_cnt   = cfg.data[SCNT_W-1:0];
					CFG_REPORT_INTERVAL:  interval_len = cfg.data[IVL_W-1:0];
					CFG_SMOOTHING_LENGTH: smooth_len   = cfg.data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (pkt.valid && pkt.ready)
				tally_packet(pkt.stream_number, pkt.packet_bytes);
			pending = report_queue.size();
		end
	end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// Stream bitrate statistics testbench
// Drives packets and register writes into the block and accepts its records
// with random gaps on both sides. A directed part covers byte extremes,
// streams out of use, interval and length corner values and a lowered
// interval; random phases at several settings follow, one of them with no
// gaps on either side. The checker beside the block predicts and compares;
// a watchdog ends a run that stops making progress.
// ----------------------------------------------------------------------------
module tb_top;
	import sbs_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 11;
	localparam int IDLE_PCT      = 11;
	localparam int SETTLE_CYCLES = 16;
	localparam int QUIET_LIMIT   = 4000;

	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
	localparam logic [PKT_W-1:0]     PKT_MAX      = '1;

	logic clk;
	logic arst_n;
	bit   steady;
	int   fail_count;
	int   pending;
	int   quiet_cycles;

	sbs_cfg_if cfg_ch ();
	sbs_pkt_if pkt_ch ();
	sbs_rec_if rec_ch ();

	stream_bitrate_statistics u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pkt    (pkt_ch),
		.rec    (rec_ch)
	);

	sbs_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.pkt        (pkt_ch),
		.rec        (rec_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(negedge clk) begin
		rec_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (!arst_n || (cfg_ch.valid && cfg_ch.ready) || (pkt_ch.valid && pkt_ch.ready) ||
			(rec_ch.valid && rec_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("stream_bitrate_statistics test failed");
			$finish;
		end
	end

	task automatic send_packet(input logic [SID_W-1:0] sid, input logic [PKT_W-1:0] nbytes);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			pkt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pkt_ch.valid         <= 1'b1;
		pkt_ch.stream_number <= sid;
		pkt_ch.packet_bytes  <= nbytes;
		do @(posedge clk); while (!pkt_ch.ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// hold the sender until every predicted record has come back
	task automatic wait_results();
		@(negedge clk);
		pkt_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic drain();
		wait_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input logic [SID_W-1:0] video, input logic [SCNT_W-1:0] count,
		input logic [IVL_W-1:0] ivl, input logic [LEN_W-1:0] len);
		write_reg(CFG_VIDEO_STREAM, {12'($urandom), video});
		write_reg(CFG_STREAM_COUNT, {11'($urandom), count});
		write_reg(CFG_REPORT_INTERVAL, ivl);
		write_reg(CFG_SMOOTHING_LENGTH, {5'($urandom), len});
	endtask

	task automatic random_packets(input int n, input logic [SID_W-1:0] video, input int span);
		logic [SID_W-1:0] sid;
		logic [PKT_W-1:0] nbytes;
		int               pick;
		for (int k = 0; k < n; k++) begin
			if (k == n / 2 || $urandom_range(19) == 0)
				wait_results();
			pick = $urandom_range(99);
			if (pick < 35)
				sid = video;
			else if (pick < 45)
				sid = SID_W'($urandom);
			else
				sid = SID_W'($urandom_range(span - 1));
			pick = $urandom_range(99);
			if (pick < 10)
				nbytes = '0;
			else if (pick < 20)
				nbytes = PKT_MAX;
			else if (pick < 50)
				nbytes = PKT_W'($urandom_range(255));
			else
				nbytes = PKT_W'($urandom);
			send_packet(sid, nbytes);
		end
	endtask

	initial begin
		int               span;
		logic [SID_W-1:0] vsel;

		clk                  = 1'b0;
		arst_n               = 1'b0;
		steady               = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = '0;
		cfg_ch.data          = '0;
		pkt_ch.valid         = 1'b0;
		pkt_ch.stream_number = '0;
		pkt_ch.packet_bytes  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: video stream 0, all streams, report on every frame
		send_packet(4'd0, '0);
		send_packet(4'd5, PKT_MAX);
		send_packet(4'd15, PKT_MAX);
		send_packet(4'd10, 24'd1);
		send_packet(4'd0, 24'h123456);
		send_packet(4'd0, '0);
		send_packet(4'd15, '0);
		send_packet(4'd3, PKT_MAX);
		send_packet(4'd0, PKT_MAX);

		// streams out of use are dropped
		drain();
		write_reg(CFG_STREAM_COUNT, 16'hffe5);
		write_reg(CFG_VIDEO_STREAM, 16'hfff0);
		send_packet(4'd7, PKT_MAX);
		send_packet(4'd12, 24'd5);
		send_packet(4'd4, 24'h800000);
		send_packet(4'd0, 24'd1);

		// lower the interval below the frame counter
		drain();
		write_reg(CFG_REPORT_INTERVAL, 16'hffff);
		write_reg(CFG_SMOOTHING_LENGTH, 16'h0400);
		send_packet(4'd1, 24'd9);
		send_packet(4'd0, 24'd2);
		send_packet(4'd0, 24'd3);
		send_packet(4'd0, 24'd4);
		drain();
		write_reg(CFG_REPORT_INTERVAL, 16'd2);
		send_packet(4'd0, 24'h00ffff);

		// video stream beyond the count never reports
		drain();
		write_reg(CFG_UNMAPPED, 16'($urandom));
		write_reg(CFG_STREAM_COUNT, 16'd2);
		write_reg(CFG_VIDEO_STREAM, 16'd4);
		send_packet(4'd4, PKT_MAX);
		send_packet(4'd1, 24'd7);

		// zero interval and zero length act as one
		drain();
		write_reg(CFG_REPORT_INTERVAL, 16'd0);
		write_reg(CFG_SMOOTHING_LENGTH, 16'hf800);
		write_reg(CFG_VIDEO_STREAM, 16'd1);
		send_packet(4'd1, PKT_MAX);
		send_packet(4'd1, 24'd1);

		drain();
		configure(4'd2, 5'd4, 16'd3, 11'd1024);
		random_packets(25, 4'd2, 4);

		drain();
		steady = 1'b1;
		configure(4'd15, 5'd31, 16'd0, 11'd0);
		random_packets(25, 4'd15, 16);
		steady = 1'b0;

		drain();
		configure(4'd0, 5'd0, 16'd2, 11'd2047);
		random_packets(15, 4'd0, 1);

		drain();
		span = $urandom_range(1, 16);
		vsel = SID_W'($urandom_range(span - 1));
		configure(vsel, SCNT_W'(span), IVL_W'($urandom_range(1, 4)),
			LEN_W'($urandom_range(1, 1024)));
		random_packets(25, vsel, span);

		drain();
		if (fail_count == 0 && pending == 0)
			$display("stream_bitrate_statistics test passed");
		else
			$display("stream_bitrate_statistics test failed");
		$finish;
	end

endmodule
